// File: rtl/core/timed_event_priority_queue_assert.svh
// assertion helpers used by the queue datapath
`ifndef TIMED_EVENT_PRIORITY_QUEUE_ASSERT_SVH
`define TIMED_EVENT_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, held off during reset
`define TEPQ_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tepq assertion failed");

// next-cycle implication, held off during reset
`define TEPQ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tepq assertion failed");

`endif

// File: rtl/core/tepq_pkg.sv
`timescale 1ns / 1ps

package tepq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS         = 6;
    localparam int TIME_BITS       = 64;
    localparam int MAX_RESULTS     = 16;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] REQ_SCHED  = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_RUN    = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_FIRE = 2'd1;
    localparam logic [1:0] KIND_FULL = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [ID_BITS-1:0]   event_id;
        logic [TIME_BITS-1:0] due_time;
    } req_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [ID_BITS-1:0]   fired_id;
        logic [TIME_BITS-1:0] next_due;
        logic                 last;
    } rsp_t;

    typedef struct packed {
        logic       take_req;
        logic       scan_start;
        logic       clear_all;
        logic       sched_write;
        logic       fire_take;
        logic       use_scan_min;
        logic       out_load;
        logic [1:0] out_kind;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic       scan_done;
        logic       free_found;
        logic       best_found;
        logic       best_due;
        logic       cnt_full;
        logic       pending;
        logic       out_free;
        logic [1:0] req_type;
    } sts_t;

endpackage

// File: rtl/core/tepq_ctrl.sv
`timescale 1ns / 1ps

module tepq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  tepq_pkg::sts_t    sts,
    output tepq_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   fire_now;

    assign req_stall = (state_reg != ST_IDLE);
    assign fire_now  = sts.best_found && sts.best_due && !sts.cnt_full;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take_req = 1'b1;
                    state_next   = ST_START;
                end
            end
            ST_START:
            begin
                if (sts.req_type == tepq_pkg::REQ_CLEAR)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_kind = tepq_pkg::KIND_ACK;
                    state_next   = ST_IDLE;
                    unique case (sts.req_type)
                        tepq_pkg::REQ_SCHED:
                        begin
                            if (sts.free_found)
                            begin
                                cmd.sched_write = 1'b1;
                            end
                            else
                            begin
                                cmd.out_kind = tepq_pkg::KIND_FULL;
                            end
                        end
                        tepq_pkg::REQ_CANCEL:
                        begin
                            cmd.use_scan_min = 1'b1;
                        end
                        tepq_pkg::REQ_CLEAR:
                        begin
                            cmd.clear_all = 1'b1;
                        end
                        tepq_pkg::REQ_RUN:
                        begin
                            cmd.use_scan_min = 1'b1;
                            // the previously taken event is reported once the next minimum is known
                            if (sts.pending)
                            begin
                                cmd.out_kind = tepq_pkg::KIND_FIRE;
                                cmd.out_last = !fire_now;
                            end
                            else if (fire_now)
                            begin
                                cmd.out_load = 1'b0;
                            end
                            else
                            begin
                                cmd.out_kind = tepq_pkg::KIND_NONE;
                            end
                            if (fire_now)
                            begin
                                cmd.fire_take  = 1'b1;
                                cmd.scan_start = 1'b1;
                                state_next     = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/tepq_dp.sv
`timescale 1ns / 1ps
`include "timed_event_priority_queue_assert.svh"

module tepq_dp
#(
    parameter int QUEUE_DEPTH = tepq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tepq_pkg::req_t    req,
    input  tepq_pkg::cmd_t    cmd,
    output tepq_pkg::sts_t    sts,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output tepq_pkg::rsp_t    rsp
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int TW    = tepq_pkg::TIME_BITS;
    localparam int IW    = tepq_pkg::ID_BITS;

    // slot storage
    logic [TW-1:0] time_mem [QUEUE_DEPTH];
    logic [IW-1:0] id_mem   [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [QUEUE_DEPTH-1:0] valid_next;
    logic [TW-1:0]          earliest_reg;
    logic [TW-1:0]          earliest_next;

    tepq_pkg::req_t         req_reg;

    // scan pipeline: address stage then compare stage
    logic                   issue_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   d_vld_reg;
    logic [IDX_W-1:0]       d_idx_reg;
    logic [TW-1:0]          rd_time_reg;
    logic [IW-1:0]          rd_id_reg;

    logic                   best_found_reg;
    logic [TW-1:0]          best_time_reg;
    logic [IW-1:0]          best_id_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic                   free_found_reg;
    logic [IDX_W-1:0]       free_idx_reg;

    logic                   pending_reg;
    logic [IW-1:0]          pending_id_reg;
    logic [tepq_pkg::CNT_W-1:0] fire_cnt_reg;

    logic                   rsp_valid_reg;
    tepq_pkg::rsp_t         rsp_reg;
    tepq_pkg::rsp_t         rsp_next;

    logic                   out_free;
    logic                   slot_live;
    logic                   is_better;
    logic                   cancel_hit;
    logic                   min_cand;
    logic                   free_cand;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign slot_live = d_vld_reg && valid_reg[d_idx_reg];
    assign is_better = !best_found_reg || (rd_time_reg < best_time_reg) ||
                       ((rd_time_reg == best_time_reg) && (rd_id_reg < best_id_reg));

    assign cancel_hit = slot_live && (req_reg.req_type == tepq_pkg::REQ_CANCEL) &&
                        (rd_id_reg == req_reg.event_id);
    assign min_cand   = slot_live && !cancel_hit && is_better &&
                        ((req_reg.req_type == tepq_pkg::REQ_RUN) ||
                         (req_reg.req_type == tepq_pkg::REQ_CANCEL));
    assign free_cand  = d_vld_reg && !valid_reg[d_idx_reg] && !free_found_reg &&
                        (req_reg.req_type == tepq_pkg::REQ_SCHED);

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clear_all)
        begin
            valid_next = '0;
        end
        else
        begin
            if (cmd.sched_write)
            begin
                valid_next[free_idx_reg] = 1'b1;
            end
            if (cmd.fire_take)
            begin
                valid_next[best_idx_reg] = 1'b0;
            end
            if (cancel_hit)
            begin
                valid_next[d_idx_reg] = 1'b0;
            end
        end
    end

    always_comb
    begin
        earliest_next = earliest_reg;
        if (cmd.clear_all)
        begin
            earliest_next = '1;
        end
        else if (cmd.sched_write)
        begin
            earliest_next = (req_reg.due_time < earliest_reg) ? req_reg.due_time : earliest_reg;
        end
        else if (cmd.use_scan_min)
        begin
            earliest_next = best_found_reg ? best_time_reg : '1;
        end
    end

    always_comb
    begin
        rsp_next.kind     = cmd.out_kind;
        rsp_next.fired_id = (cmd.out_kind == tepq_pkg::KIND_FIRE) ? pending_id_reg : '0;
        rsp_next.next_due = earliest_next;
        rsp_next.last     = cmd.out_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            earliest_reg   <= '1;
            issue_reg      <= 1'b0;
            idx_reg        <= '0;
            d_vld_reg      <= 1'b0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            pending_reg    <= 1'b0;
            fire_cnt_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            earliest_reg <= earliest_next;
            d_vld_reg    <= issue_reg;

            if (cmd.scan_start)
            begin
                issue_reg      <= 1'b1;
                idx_reg        <= '0;
                best_found_reg <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (issue_reg)
                begin
                    if (idx_reg == IDX_W'(QUEUE_DEPTH - 1))
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                if (min_cand)
                begin
                    best_found_reg <= 1'b1;
                end
                if (free_cand)
                begin
                    free_found_reg <= 1'b1;
                end
            end

            if (cmd.take_req)
            begin
                pending_reg  <= 1'b0;
                fire_cnt_reg <= '0;
            end
            else if (cmd.fire_take)
            begin
                pending_reg  <= 1'b1;
                fire_cnt_reg <= fire_cnt_reg + 1'b1;
            end

            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers and slot memory
    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            req_reg <= req;
        end
        if (issue_reg)
        begin
            rd_time_reg <= time_mem[idx_reg];
            rd_id_reg   <= id_mem[idx_reg];
        end
        d_idx_reg <= idx_reg;
        if (cmd.sched_write)
        begin
            time_mem[free_idx_reg] <= req_reg.due_time;
            id_mem[free_idx_reg]   <= req_reg.event_id;
        end
        if (min_cand && !cmd.scan_start)
        begin
            best_time_reg <= rd_time_reg;
            best_id_reg   <= rd_id_reg;
            best_idx_reg  <= d_idx_reg;
        end
        if (free_cand && !cmd.scan_start)
        begin
            free_idx_reg <= d_idx_reg;
        end
        if (cmd.fire_take)
        begin
            pending_id_reg <= best_id_reg;
        end
        if (cmd.out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        sts.scan_done  = !issue_reg && !d_vld_reg;
        sts.free_found = free_found_reg;
        sts.best_found = best_found_reg;
        sts.best_due   = (best_time_reg <= req_reg.due_time);
        sts.cnt_full   = (fire_cnt_reg == tepq_pkg::CNT_W'(tepq_pkg::MAX_RESULTS));
        sts.pending    = pending_reg;
        sts.out_free   = out_free;
        sts.req_type   = req_reg.req_type;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `TEPQ_ASSERT_NOW(a_load_needs_room, clk, rst_n, cmd.out_load, out_free)
    `TEPQ_ASSERT_NOW(a_write_free_slot, clk, rst_n, cmd.sched_write, free_found_reg && !valid_reg[free_idx_reg])
    `TEPQ_ASSERT_NOW(a_fire_live_slot, clk, rst_n, cmd.fire_take, best_found_reg && valid_reg[best_idx_reg])
    `TEPQ_ASSERT_NXT(a_fire_clears_slot, clk, rst_n, cmd.fire_take && !cmd.clear_all, !valid_reg[$past(best_idx_reg)])

endmodule

// File: rtl/core/timed_event_priority_queue.sv
`timescale 1ns / 1ps
// channel    direction  payload            handshake
// request    in         tepq_pkg::req_t    req_valid / req_stall
// response   out        tepq_pkg::rsp_t    rsp_valid / rsp_stall
//
// one slot scan reads every slot in turn through the single read port of the slot memory
// schedule and cancel each run one slot scan before their response is loaded
// clear skips the scan; each scan is followed by a decision step
// run until with k fired events takes k + 1 scans
// one request at a time; req_stall stays high until its final response is loaded
// a stalled response holds the block in its decision step until the output register frees
// reset empties the queue and sets the earliest due time to all ones

module timed_event_priority_queue
#(
    parameter int QUEUE_DEPTH = tepq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  tepq_pkg::req_t    req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output tepq_pkg::rsp_t    rsp
);

    tepq_pkg::cmd_t cmd;
    tepq_pkg::sts_t sts;

    tepq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    tepq_dp
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tepq_pkg::*;

    localparam int QDEPTH = QUEUE_DEPTH_DEF;
    localparam logic [TIME_BITS-1:0] NEVER = '1;

    typedef struct {
        req_t r;
        int   reps;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // shadow copy of the event slots
    logic                 sh_live [QDEPTH];
    logic [TIME_BITS-1:0] sh_due  [QDEPTH];
    logic [ID_BITS-1:0]   sh_id   [QDEPTH];
    logic [TIME_BITS-1:0] sh_next = NEVER;

    rsp_t awaited_rsp[$];
    dir_row_t dir_table[$];

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int n_fail = 0;
    int n_req = 0;
    int n_rsp = 0;
    int n_fired = 0;
    int n_full = 0;
    logic [TIME_BITS-1:0] sim_now = 64'd0;
    logic [TIME_BITS-1:0] recent_due = 64'd0;

    timed_event_priority_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic rsp_t make_rsp(logic [1:0] kind, logic [ID_BITS-1:0] id,
                                      logic [TIME_BITS-1:0] nd, logic last);
        rsp_t x;
        x.kind = kind;
        x.fired_id = id;
        x.next_due = nd;
        x.last = last;
        return x;
    endfunction

    function automatic req_t make_req(logic [1:0] op, logic [ID_BITS-1:0] id,
                                      logic [TIME_BITS-1:0] t);
        req_t x;
        x.req_type = op;
        x.event_id = id;
        x.due_time = t;
        return x;
    endfunction

    function automatic dir_row_t row(logic [1:0] op, logic [ID_BITS-1:0] id,
                                     logic [TIME_BITS-1:0] t, int reps, bit typed,
                                     rsp_t want);
        dir_row_t x;
        x.r = make_req(op, id, t);
        x.reps = reps;
        x.typed = typed;
        x.want = want;
        return x;
    endfunction

    // earliest slot, ties to the lower id, then the lower slot
    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int i = 0; i < QDEPTH; i++) begin
            if (!sh_live[i])
                continue;
            if (best < 0 || sh_due[i] < sh_due[best] ||
                (sh_due[i] == sh_due[best] && sh_id[i] < sh_id[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic void refresh_next();
        int m;
        m = earliest_slot();
        sh_next = (m < 0) ? NEVER : sh_due[m];
    endfunction

    function automatic void apply_request(req_t r);
        int slot;
        int fired;
        int m;
        rsp_t tail;
        case (r.req_type)
            REQ_SCHED: begin
                slot = -1;
                for (int i = 0; i < QDEPTH; i++)
                    if (!sh_live[i] && slot < 0)
                        slot = i;
                if (slot < 0) begin
                    awaited_rsp.push_back(make_rsp(KIND_FULL, '0, sh_next, 1'b1));
                end
                else begin
                    sh_live[slot] = 1'b1;
                    sh_due[slot] = r.due_time;
                    sh_id[slot] = r.event_id;
                    refresh_next();
                    awaited_rsp.push_back(make_rsp(KIND_ACK, '0, sh_next, 1'b1));
                end
            end
            REQ_CANCEL: begin
                for (int i = 0; i < QDEPTH; i++)
                    if (sh_live[i] && sh_id[i] == r.event_id)
                        sh_live[i] = 1'b0;
                refresh_next();
                awaited_rsp.push_back(make_rsp(KIND_ACK, '0, sh_next, 1'b1));
            end
            REQ_RUN: begin
                fired = 0;
                while (fired < MAX_RESULTS) begin
                    m = earliest_slot();
                    if (m < 0 || sh_due[m] > r.due_time)
                        break;
                    sh_live[m] = 1'b0;
                    refresh_next();
                    awaited_rsp.push_back(make_rsp(KIND_FIRE, sh_id[m], sh_next, 1'b0));
                    fired++;
                end
                if (fired == 0) begin
                    refresh_next();
                    awaited_rsp.push_back(make_rsp(KIND_NONE, '0, sh_next, 1'b1));
                end
                else begin
                    tail = awaited_rsp.pop_back();
                    tail.last = 1'b1;
                    awaited_rsp.push_back(tail);
                end
            end
            default: begin
                for (int i = 0; i < QDEPTH; i++)
                    sh_live[i] = 1'b0;
                sh_next = NEVER;
                awaited_rsp.push_back(make_rsp(KIND_ACK, '0, sh_next, 1'b1));
            end
        endcase
    endfunction

    // called at a rising edge; returns at the edge where the request was taken
    task automatic send_request(req_t r, bit typed, rsp_t want);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        apply_request(r);
        if (typed) begin
            void'(awaited_rsp.pop_back());
            awaited_rsp.push_back(want);
        end
        n_req++;
    endtask

    task automatic check_rsp(rsp_t got);
        rsp_t want;
        if (awaited_rsp.size() == 0) begin
            $error("response with nothing outstanding: kind %0d id %0d next_due %h",
                   got.kind, got.fired_id, got.next_due);
            n_fail++;
            return;
        end
        want = awaited_rsp.pop_front();
        n_rsp++;
        if (got.kind == KIND_FIRE)
            n_fired++;
        if (got.kind == KIND_FULL)
            n_full++;
        if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            n_fail++;
        end
        if (got.fired_id !== want.fired_id) begin
            $error("fired_id: expected %0d, got %0d", want.fired_id, got.fired_id);
            n_fail++;
        end
        if (got.next_due !== want.next_due) begin
            $error("next_due: expected %h, got %h", want.next_due, got.next_due);
            n_fail++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            n_fail++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_valid && !rsp_stall)
                check_rsp(rsp);
            rsp_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
        end
    end

    function automatic logic [TIME_BITS-1:0] rand_time();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [TIME_BITS-1:0] pick_due();
        int p;
        p = $urandom_range(0, 99);
        if (p < 4)
            return 64'd0;
        if (p < 8)
            return NEVER;
        if (p < 14)
            return rand_time();
        // reuse a recent time to get ties
        if (p < 26)
            return recent_due;
        return sim_now + $urandom_range(0, 200);
    endfunction

    task automatic random_burst(int n);
        req_t r;
        int p;
        rsp_t none;
        none = '0;
        repeat (n) begin
            p = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0)
                r.event_id = ID_BITS'($urandom_range(0, 63));
            else
                r.event_id = ID_BITS'($urandom_range(0, 7));
            if (p < 50) begin
                r.req_type = REQ_SCHED;
                r.due_time = pick_due();
                recent_due = r.due_time;
            end
            else if (p < 65) begin
                r.req_type = REQ_CANCEL;
                r.due_time = rand_time();
            end
            else if (p < 96) begin
                r.req_type = REQ_RUN;
                if ($urandom_range(0, 19) == 0)
                    r.due_time = NEVER;
                else begin
                    r.due_time = sim_now + $urandom_range(0, 150);
                    sim_now = r.due_time;
                end
            end
            else begin
                r.req_type = REQ_CLEAR;
                r.due_time = rand_time();
            end
            send_request(r, 1'b0, none);
        end
    endtask

    initial begin
        dir_row_t d;
        req_t r;
        rsp_t none;
        none = '0;
        for (int i = 0; i < QDEPTH; i++)
            sh_live[i] = 1'b0;

        dir_table = '{
            row(REQ_RUN,    6'd0,  NEVER,        1, 1, make_rsp(KIND_NONE, 6'd0, NEVER, 1'b1)),
            row(REQ_CANCEL, 6'd21, 64'd0,        1, 1, make_rsp(KIND_ACK, 6'd0, NEVER, 1'b1)),
            row(REQ_CLEAR,  6'd0,  64'd0,        1, 1, make_rsp(KIND_ACK, 6'd0, NEVER, 1'b1)),
            row(REQ_SCHED,  6'd0,  64'd0,        1, 1, make_rsp(KIND_ACK, 6'd0, 64'd0, 1'b1)),
            row(REQ_SCHED,  6'd63, NEVER,        1, 1, make_rsp(KIND_ACK, 6'd0, 64'd0, 1'b1)),
            row(REQ_RUN,    6'd0,  64'd0,        1, 1, make_rsp(KIND_FIRE, 6'd0, NEVER, 1'b1)),
            row(REQ_RUN,    6'd0,  NEVER - 1,    1, 1, make_rsp(KIND_NONE, 6'd0, NEVER, 1'b1)),
            row(REQ_RUN,    6'd0,  NEVER,        1, 1, make_rsp(KIND_FIRE, 6'd63, NEVER, 1'b1)),
            // equal times go to the lower id, duplicates fire separately
            row(REQ_SCHED,  6'd7,  64'd100,      1, 0, none),
            row(REQ_SCHED,  6'd3,  64'd100,      1, 0, none),
            row(REQ_SCHED,  6'd7,  64'd50,       1, 0, none),
            row(REQ_SCHED,  6'd9,  64'd100,      1, 0, none),
            row(REQ_SCHED,  6'd7,  64'd200,      1, 0, none),
            row(REQ_RUN,    6'd0,  64'd100,      1, 0, none),
            row(REQ_CANCEL, 6'd7,  64'd0,        1, 0, none),
            row(REQ_CANCEL, 6'd40, 64'd0,        1, 0, none),
            // fill every slot, then one more is rejected
            row(REQ_SCHED,  6'd16, 64'd1000,    16, 0, none),
            row(REQ_SCHED,  6'd63, 64'd5,        1, 1, make_rsp(KIND_FULL, 6'd0, 64'd1000, 1'b1)),
            row(REQ_RUN,    6'd0,  64'd1003,     1, 0, none),
            row(REQ_SCHED,  6'd1,  64'd5,        1, 0, none),
            row(REQ_CLEAR,  6'd0,  64'd0,        1, 1, make_rsp(KIND_ACK, 6'd0, NEVER, 1'b1))
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i]) begin
            d = dir_table[i];
            for (int k = 0; k < d.reps; k++) begin
                r = d.r;
                if (d.reps > 1) begin
                    r.event_id = d.r.event_id + ID_BITS'(k);
                    r.due_time = d.r.due_time + (k % 4);
                end
                send_request(r, d.typed, d.want);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            snd_idle_pct  = (ph == 1) ? 49 : (ph == 3) ? 9 : 0;
            rcv_stall_pct = (ph == 2) ? 49 : (ph == 3) ? 9 : 0;
            random_burst(31);
        end
        req_valid <= 1'b0;

        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("%0d requests sent, %0d responses checked (%0d events fired, %0d rejected as full)",
                 n_req, n_rsp, n_fired, n_full);
        $display("idle and stall phases covered, %0d mismatches", n_fail);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
